// ===== src/tce_pkg.sv =====
// Shared types, constants and control/status structs for the text console engine.
// Used by tce_ctrl, tce_datapath, text_console_engine and the testbench; no dependencies.
package tce_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int SCREEN_SIZE = COLUMNS * ROWS;
    localparam int ADDR_W      = $clog2(SCREEN_SIZE);
    localparam int COL_W       = $clog2(COLUMNS);

    // field widths on the stream ports
    localparam int REQ_W     = 3;
    localparam int CHAR_W    = 8;
    localparam int INDEX_W   = 11;
    localparam int CURSOR_W  = 11;
    localparam int CELL_W    = 16;
    localparam int ATTR_W    = 8;
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 32;

    localparam logic [REQ_W-1:0] REQ_PUT       = 3'd0;
    localparam logic [REQ_W-1:0] REQ_BACKSPACE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR     = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WRITE_AT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_READ      = 3'd4;

    localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;
    localparam logic [ATTR_W-1:0] RESET_ATTR   = 8'h0F;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_CLEAR,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_BLANK_ROW,
        ST_DONE
    } state_t;

    typedef enum logic [2:0] {
        ADDR_CURSOR,
        ADDR_BACK,
        ADDR_INDEX,
        ADDR_CNT,
        ADDR_CNT_SRC
    } addr_sel_t;

    typedef enum logic [1:0] {
        WD_CHAR,
        WD_BLANK,
        WD_BLANK_RESET,
        WD_RDATA
    } wd_sel_t;

    typedef enum logic [2:0] {
        CUR_HOLD,
        CUR_INC,
        CUR_NEWLINE,
        CUR_BACK,
        CUR_ZERO,
        CUR_LAST_ROW
    } cur_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_ZERO,
        CNT_INC
    } cnt_op_t;

    typedef struct packed {
        logic      ld_req;
        logic      we;
        addr_sel_t addr_sel;
        wd_sel_t   wd_sel;
        cur_op_t   cur_op;
        cnt_op_t   cnt_op;
        logic      ld_data;
        logic      ld_result;
    } cmd_t;

    typedef struct packed {
        logic [REQ_W-1:0] req_type;
        logic             is_newline;
        logic             on_last_row;
        logic             idx_valid;
        logic             cnt_last;
        logic             cnt_scroll_end;
    } status_t;

endpackage

// ===== src/tce_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies.
module tce_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/tce_datapath.sv =====
// Datapath: request latch, cursor and column counters, sweep counter, screen RAM,
// attribute register and result register. Depends on tce_pkg and tce_ram.
module tce_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  tce_pkg::cmd_t                       cmd,
    output tce_pkg::status_t                    status,
    input  logic [tce_pkg::REQ_W-1:0]           s_tuser,
    input  logic [tce_pkg::S_TDATA_W-1:0]       s_tdata,
    input  logic                                cfg_valid,
    input  logic [tce_pkg::ATTR_W-1:0]          cfg_data,
    output logic [tce_pkg::M_TDATA_W-1:0]       m_tdata
);

    localparam int AW = tce_pkg::ADDR_W;
    localparam int CW = tce_pkg::COL_W;

    logic [tce_pkg::REQ_W-1:0]    req_reg;
    logic [tce_pkg::CHAR_W-1:0]   char_reg;
    logic [tce_pkg::INDEX_W-1:0]  index_reg;
    logic [AW-1:0]                cursor_reg, cursor_next;
    logic [CW-1:0]                col_reg, col_next;
    logic [AW-1:0]                cnt_reg, cnt_next;
    logic [tce_pkg::ATTR_W-1:0]   attr_reg;
    logic [tce_pkg::CELL_W-1:0]   data_reg;
    logic [tce_pkg::M_TDATA_W-1:0] result_reg;

    logic [AW-1:0]                ram_addr;
    logic [tce_pkg::CELL_W-1:0]   ram_wdata;
    logic [tce_pkg::CELL_W-1:0]   ram_rdata;
    logic [AW-1:0]                back_pos;

    // request fields, latched on the input transfer
    always_ff @(posedge aclk) begin
        if (cmd.ld_req) begin
            req_reg   <= s_tuser;
            char_reg  <= s_tdata[tce_pkg::CHAR_W-1:0];
            index_reg <= s_tdata[tce_pkg::CHAR_W +: tce_pkg::INDEX_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= tce_pkg::RESET_ATTR;
        end else if (cfg_valid) begin
            attr_reg <= cfg_data;
        end
    end

    assign back_pos = (cursor_reg == '0) ? '0 : cursor_reg - AW'(1);

    always_comb begin
        cursor_next = cursor_reg;
        col_next    = col_reg;
        case (cmd.cur_op)
            tce_pkg::CUR_INC: begin
                cursor_next = (cursor_reg == AW'(tce_pkg::SCREEN_SIZE - 1)) ? '0
                            : cursor_reg + AW'(1);
                col_next    = (col_reg == CW'(tce_pkg::COLUMNS - 1)) ? '0
                            : col_reg + CW'(1);
            end
            tce_pkg::CUR_NEWLINE: begin
                cursor_next = cursor_reg + AW'(tce_pkg::COLUMNS) - AW'(col_reg);
                col_next    = '0;
            end
            tce_pkg::CUR_BACK: begin
                cursor_next = back_pos;
                if (cursor_reg != '0) begin
                    col_next = (col_reg == '0) ? CW'(tce_pkg::COLUMNS - 1)
                             : col_reg - CW'(1);
                end
            end
            tce_pkg::CUR_ZERO: begin
                cursor_next = '0;
                col_next    = '0;
            end
            tce_pkg::CUR_LAST_ROW: begin
                cursor_next = AW'(tce_pkg::SCREEN_SIZE - tce_pkg::COLUMNS);
                col_next    = '0;
            end
            default: begin
                cursor_next = cursor_reg;
                col_next    = col_reg;
            end
        endcase
    end

    always_comb begin
        case (cmd.cnt_op)
            tce_pkg::CNT_ZERO: cnt_next = '0;
            tce_pkg::CNT_INC:  cnt_next = cnt_reg + AW'(1);
            default:           cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cursor_reg <= '0;
            col_reg    <= '0;
            cnt_reg    <= '0;
        end else begin
            cursor_reg <= cursor_next;
            col_reg    <= col_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_comb begin
        case (cmd.addr_sel)
            tce_pkg::ADDR_CURSOR:  ram_addr = cursor_reg;
            tce_pkg::ADDR_BACK:    ram_addr = back_pos;
            tce_pkg::ADDR_INDEX:   ram_addr = AW'(index_reg);
            tce_pkg::ADDR_CNT:     ram_addr = cnt_reg;
            tce_pkg::ADDR_CNT_SRC: ram_addr = cnt_reg + AW'(tce_pkg::COLUMNS);
            default:               ram_addr = cursor_reg;
        endcase
    end

    always_comb begin
        case (cmd.wd_sel)
            tce_pkg::WD_CHAR:        ram_wdata = {attr_reg, char_reg};
            tce_pkg::WD_BLANK:       ram_wdata = {attr_reg, tce_pkg::SPACE_CODE};
            tce_pkg::WD_BLANK_RESET: ram_wdata = {tce_pkg::RESET_ATTR, tce_pkg::SPACE_CODE};
            tce_pkg::WD_RDATA:       ram_wdata = ram_rdata;
            default:                 ram_wdata = {attr_reg, tce_pkg::SPACE_CODE};
        endcase
    end

    tce_ram #(
        .WIDTH (tce_pkg::CELL_W),
        .DEPTH (tce_pkg::SCREEN_SIZE)
    ) u_screen (
        .aclk  (aclk),
        .we    (cmd.we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // non-read requests report zero cell data
    always_ff @(posedge aclk) begin
        if (cmd.ld_req) begin
            data_reg <= '0;
        end else if (cmd.ld_data && status.idx_valid) begin
            data_reg <= ram_rdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_result) begin
            result_reg <= tce_pkg::M_TDATA_W'({data_reg, tce_pkg::CURSOR_W'(cursor_reg)});
        end
    end

    assign m_tdata = result_reg;

    assign status.req_type       = req_reg;
    assign status.is_newline     = (char_reg == tce_pkg::NEWLINE_CODE);
    assign status.on_last_row    = (cursor_reg >= AW'(tce_pkg::SCREEN_SIZE - tce_pkg::COLUMNS));
    assign status.idx_valid      = (index_reg < tce_pkg::INDEX_W'(tce_pkg::SCREEN_SIZE));
    assign status.cnt_last       = (cnt_reg == AW'(tce_pkg::SCREEN_SIZE - 1));
    assign status.cnt_scroll_end =
        (cnt_reg == AW'(tce_pkg::SCREEN_SIZE - tce_pkg::COLUMNS - 1));

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cursor_reg < AW'(tce_pkg::SCREEN_SIZE))
        else $error("cursor beyond screen");

    a_col_range: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg < CW'(tce_pkg::COLUMNS))
        else $error("column counter beyond row");

    a_write_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.we |-> ram_addr < AW'(tce_pkg::SCREEN_SIZE))
        else $error("store write off screen");

endmodule

// ===== src/tce_ctrl.sv =====
// Controller state machine: sequences the clearing pass, requests, scroll and clear
// sweeps, and the result handshake. Depends on tce_pkg.
module tce_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    input  tce_pkg::status_t status,
    output tce_pkg::cmd_t    cmd
);

    tce_pkg::state_t state_reg, state_next;
    logic            m_tvalid_reg, m_tvalid_next;
    logic            out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= tce_pkg::ST_INIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_tready      = 1'b0;
        cmd.ld_req    = 1'b0;
        cmd.we        = 1'b0;
        cmd.addr_sel  = tce_pkg::ADDR_CNT;
        cmd.wd_sel    = tce_pkg::WD_BLANK;
        cmd.cur_op    = tce_pkg::CUR_HOLD;
        cmd.cnt_op    = tce_pkg::CNT_HOLD;
        cmd.ld_data   = 1'b0;
        cmd.ld_result = 1'b0;
        m_tvalid_next = m_tready ? 1'b0 : m_tvalid_reg;

        case (state_reg)
            tce_pkg::ST_INIT: begin
                cmd.we     = 1'b1;
                cmd.wd_sel = tce_pkg::WD_BLANK_RESET;
                if (status.cnt_last) begin
                    cmd.cnt_op = tce_pkg::CNT_ZERO;
                    state_next = tce_pkg::ST_IDLE;
                end else begin
                    cmd.cnt_op = tce_pkg::CNT_INC;
                end
            end
            tce_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.ld_req = 1'b1;
                    state_next = tce_pkg::ST_EXEC;
                end
            end
            tce_pkg::ST_EXEC: begin
                state_next = tce_pkg::ST_DONE;
                case (status.req_type)
                    tce_pkg::REQ_PUT: begin
                        if (!status.is_newline) begin
                            cmd.we       = 1'b1;
                            cmd.addr_sel = tce_pkg::ADDR_CURSOR;
                            cmd.wd_sel   = tce_pkg::WD_CHAR;
                            cmd.cur_op   = tce_pkg::CUR_INC;
                        end else if (status.on_last_row) begin
                            cmd.cur_op = tce_pkg::CUR_LAST_ROW;
                            cmd.cnt_op = tce_pkg::CNT_ZERO;
                            state_next = tce_pkg::ST_SCR_RD;
                        end else begin
                            cmd.cur_op = tce_pkg::CUR_NEWLINE;
                        end
                    end
                    tce_pkg::REQ_BACKSPACE: begin
                        cmd.we       = 1'b1;
                        cmd.addr_sel = tce_pkg::ADDR_BACK;
                        cmd.wd_sel   = tce_pkg::WD_BLANK;
                        cmd.cur_op   = tce_pkg::CUR_BACK;
                    end
                    tce_pkg::REQ_CLEAR: begin
                        cmd.cur_op = tce_pkg::CUR_ZERO;
                        cmd.cnt_op = tce_pkg::CNT_ZERO;
                        state_next = tce_pkg::ST_CLEAR;
                    end
                    tce_pkg::REQ_WRITE_AT: begin
                        cmd.we       = status.idx_valid;
                        cmd.addr_sel = tce_pkg::ADDR_INDEX;
                        cmd.wd_sel   = tce_pkg::WD_CHAR;
                    end
                    tce_pkg::REQ_READ: begin
                        cmd.addr_sel = tce_pkg::ADDR_INDEX;
                        state_next   = tce_pkg::ST_READ;
                    end
                    default: begin
                        state_next = tce_pkg::ST_DONE;
                    end
                endcase
            end
            tce_pkg::ST_READ: begin
                cmd.ld_data = 1'b1;
                state_next  = tce_pkg::ST_DONE;
            end
            tce_pkg::ST_CLEAR: begin
                cmd.we     = 1'b1;
                cmd.wd_sel = tce_pkg::WD_BLANK;
                if (status.cnt_last) begin
                    cmd.cnt_op = tce_pkg::CNT_ZERO;
                    state_next = tce_pkg::ST_DONE;
                end else begin
                    cmd.cnt_op = tce_pkg::CNT_INC;
                end
            end
            tce_pkg::ST_SCR_RD: begin
                // fetch the cell one row below the destination
                cmd.addr_sel = tce_pkg::ADDR_CNT_SRC;
                state_next   = tce_pkg::ST_SCR_WR;
            end
            tce_pkg::ST_SCR_WR: begin
                cmd.we     = 1'b1;
                cmd.wd_sel = tce_pkg::WD_RDATA;
                cmd.cnt_op = tce_pkg::CNT_INC;
                state_next = status.cnt_scroll_end ? tce_pkg::ST_BLANK_ROW
                                                   : tce_pkg::ST_SCR_RD;
            end
            tce_pkg::ST_BLANK_ROW: begin
                cmd.we     = 1'b1;
                cmd.wd_sel = tce_pkg::WD_BLANK;
                if (status.cnt_last) begin
                    cmd.cnt_op = tce_pkg::CNT_ZERO;
                    state_next = tce_pkg::ST_DONE;
                end else begin
                    cmd.cnt_op = tce_pkg::CNT_INC;
                end
            end
            tce_pkg::ST_DONE: begin
                // hold here until the output register can take the result
                if (out_free) begin
                    cmd.ld_result = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = tce_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tce_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;

    a_accept_to_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == tce_pkg::ST_EXEC)
        else $error("accepted request not executed");

    a_result_load_safe: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_result |-> out_free)
        else $error("result overwritten before transfer");

    a_result_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.ld_result |=> m_tvalid_reg)
        else $error("loaded result not offered");

    a_no_write_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == tce_pkg::ST_IDLE |-> !cmd.we)
        else $error("store written while idle");

endmodule

// ===== src/text_console_engine.sv =====
// Top level of the text console engine: ties the controller to the datapath.
// Depends on tce_pkg, tce_ctrl, tce_datapath (and tce_ram through the datapath).
//
// Character-cell console of COLUMNS x ROWS 16-bit cells (character low byte,
// attribute high byte) in a single-port RAM. Every cell access goes through the
// one RAM port, so a clear writes the cells one after another and a newline on the
// last row copies each cell up one row, a read then a write per cell, before it
// blanks the last row. One request is handled at a time; the next is taken while
// the previous result still waits in the output register. After reset the block
// sweeps the store to blank cells with the reset attribute and takes no request
// meanwhile; attribute writes are taken at any time.
module text_console_engine (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tce_pkg::S_TDATA_W-1:0]     s_tdata,   // char_code[7:0], cell_index[18:8]
    input  logic [tce_pkg::REQ_W-1:0]         s_tuser,   // req_type[2:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tce_pkg::M_TDATA_W-1:0]     m_tdata,   // cursor_pos[10:0], cell_data[26:11]
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tce_pkg::ATTR_W-1:0]        cfg_data   // text_attribute
);

    tce_pkg::cmd_t    cmd;
    tce_pkg::status_t status;

    assign cfg_ready = 1'b1;

    tce_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tce_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .status    (status),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== tb/sv/text_console_engine_test.sv =====
// Self-checking testbench for text_console_engine: directed probes, then random
// text, scrolling and cell traffic checked against a behavioural screen model.
// Depends on tce_pkg and the text_console_engine RTL.
module text_console_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    // request codes with no operation behind them
    localparam logic [tce_pkg::REQ_W-1:0] REQ_SPARE_LO  = 3'd5;
    localparam logic [tce_pkg::REQ_W-1:0] REQ_SPARE_MID = 3'd6;
    localparam logic [tce_pkg::REQ_W-1:0] REQ_SPARE_HI  = 3'd7;

    localparam int RANDOM_ITEMS = 950;
    localparam int CFG_SPACING  = 120;
    localparam int IDLE_PERCENT = 22;
    // scrolls and clears each hold the input while they sweep the screen
    localparam int LIMIT_CYCLES = 20000000;
    localparam int TAIL_CYCLES  = 50;

    typedef struct packed {
        logic [tce_pkg::CURSOR_W-1:0] cursor;
        logic [tce_pkg::CELL_W-1:0]   cell_data;
    } console_result_t;

    typedef struct packed {
        logic [tce_pkg::REQ_W-1:0]   req;
        logic [tce_pkg::CHAR_W-1:0]  ch;
        logic [tce_pkg::INDEX_W-1:0] idx;
        logic                        has_fixed;
        console_result_t             fixed_res;
    } probe_row_t;

    localparam int NUM_PROBES = 24;
    localparam probe_row_t PROBE_TABLE [0:NUM_PROBES-1] = '{
        '{tce_pkg::REQ_READ,      8'h00, 11'd0,    1'b1, '{11'd0,   16'h0F20}},
        '{tce_pkg::REQ_READ,      8'h00, 11'd1999, 1'b1, '{11'd0,   16'h0F20}},
        '{tce_pkg::REQ_READ,      8'hFF, 11'd2047, 1'b1, '{11'd0,   16'h0000}},
        '{tce_pkg::REQ_BACKSPACE, 8'h00, 11'd0,    1'b1, '{11'd0,   16'h0000}},
        '{tce_pkg::REQ_PUT,       8'h41, 11'd0,    1'b1, '{11'd1,   16'h0000}},
        '{tce_pkg::REQ_READ,      8'h00, 11'd0,    1'b1, '{11'd1,   16'h0F41}},
        '{tce_pkg::REQ_PUT,       8'h00, 11'd0,    1'b0, '{11'd0,   16'h0000}},
        '{tce_pkg::REQ_PUT,       8'hFF, 11'd2047, 1'b0, '{11'd0,   16'h0000}},
        '{tce_pkg::REQ_BACKSPACE, 8'hFF, 11'd2047, 1'b1, '{11'd2,   16'h0000}},
        '{tce_pkg::REQ_READ,      8'h00, 11'd2,    1'b1, '{11'd2,   16'h0F20}},
        '{tce_pkg::REQ_READ,      8'h00, 11'd1,    1'b0, '{11'd0,   16'h0000}},
        '{tce_pkg::REQ_WRITE_AT,  8'hFF, 11'd1999, 1'b1, '{11'd2,   16'h0000}},
        '{tce_pkg::REQ_READ,      8'h00, 11'd1999, 1'b1, '{11'd2,   16'h0FFF}},
        '{tce_pkg::REQ_WRITE_AT,  8'h55, 11'd2000, 1'b1, '{11'd2,   16'h0000}},
        '{tce_pkg::REQ_WRITE_AT,  8'hAA, 11'd2047, 1'b1, '{11'd2,   16'h0000}},
        '{tce_pkg::REQ_READ,      8'h00, 11'd2000, 1'b1, '{11'd2,   16'h0000}},
        '{tce_pkg::REQ_PUT, tce_pkg::NEWLINE_CODE, 11'd0, 1'b1, '{11'd80, 16'h0000}},
        '{tce_pkg::REQ_PUT, tce_pkg::NEWLINE_CODE, 11'd2047, 1'b1, '{11'd160, 16'h0000}},
        '{REQ_SPARE_LO,           8'hFF, 11'd2047, 1'b1, '{11'd160, 16'h0000}},
        '{REQ_SPARE_MID,          8'h00, 11'd0,    1'b1, '{11'd160, 16'h0000}},
        '{REQ_SPARE_HI,           8'h55, 11'd682,  1'b1, '{11'd160, 16'h0000}},
        '{tce_pkg::REQ_CLEAR,     8'hFF, 11'd2047, 1'b1, '{11'd0,   16'h0000}},
        '{tce_pkg::REQ_READ,      8'h00, 11'd1999, 1'b0, '{11'd0,   16'h0000}},
        '{tce_pkg::REQ_READ,      8'h00, 11'd0,    1'b1, '{11'd0,   16'h0F20}}
    };

    logic                          aclk;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [tce_pkg::S_TDATA_W-1:0] s_tdata   = '0;
    logic [tce_pkg::REQ_W-1:0]     s_tuser   = tce_pkg::REQ_PUT;
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [tce_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tce_pkg::ATTR_W-1:0]    cfg_data  = '0;

    // screen model
    logic [tce_pkg::CELL_W-1:0] model_cells [0:tce_pkg::SCREEN_SIZE-1];
    int                         model_cursor;
    logic [tce_pkg::ATTR_W-1:0] model_attr;

    console_result_t pending_results [$];
    console_result_t oldest;
    int              fail_count  = 0;
    int              cycle_count = 0;
    int              stim_count  = 0;
    int              last_written = 0;
    bit              quiet = 1'b0;

    text_console_engine uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic predict_console(input logic [tce_pkg::REQ_W-1:0] req,
                                   input logic [tce_pkg::CHAR_W-1:0] ch,
                                   input logic [tce_pkg::INDEX_W-1:0] idx,
                                   output console_result_t res);
        res.cell_data = '0;
        case (req)
            tce_pkg::REQ_PUT: begin
                if (ch == tce_pkg::NEWLINE_CODE) begin
                    if (model_cursor >= tce_pkg::SCREEN_SIZE - tce_pkg::COLUMNS) begin
                        for (int i = tce_pkg::COLUMNS; i < tce_pkg::SCREEN_SIZE; i++)
                            model_cells[i-tce_pkg::COLUMNS] = model_cells[i];
                        for (int i = tce_pkg::SCREEN_SIZE - tce_pkg::COLUMNS;
                             i < tce_pkg::SCREEN_SIZE; i++)
                            model_cells[i] = {model_attr, tce_pkg::SPACE_CODE};
                        model_cursor = tce_pkg::SCREEN_SIZE - tce_pkg::COLUMNS;
                    end else begin
                        model_cursor = (model_cursor / tce_pkg::COLUMNS + 1) * tce_pkg::COLUMNS;
                    end
                end else begin
                    model_cells[model_cursor] = {model_attr, ch};
                    model_cursor = (model_cursor + 1) % tce_pkg::SCREEN_SIZE;
                end
            end
            tce_pkg::REQ_BACKSPACE: begin
                if (model_cursor > 0)
                    model_cursor = model_cursor - 1;
                model_cells[model_cursor] = {model_attr, tce_pkg::SPACE_CODE};
            end
            tce_pkg::REQ_CLEAR: begin
                for (int i = 0; i < tce_pkg::SCREEN_SIZE; i++)
                    model_cells[i] = {model_attr, tce_pkg::SPACE_CODE};
                model_cursor = 0;
            end
            tce_pkg::REQ_WRITE_AT: begin
                if (idx < tce_pkg::SCREEN_SIZE)
                    model_cells[idx] = {model_attr, ch};
            end
            tce_pkg::REQ_READ: begin
                if (idx < tce_pkg::SCREEN_SIZE)
                    res.cell_data = model_cells[idx];
            end
            default: ;
        endcase
        res.cursor = model_cursor[tce_pkg::CURSOR_W-1:0];
    endtask

    task automatic send_request(input logic [tce_pkg::REQ_W-1:0] req,
                                input logic [tce_pkg::CHAR_W-1:0] ch,
                                input logic [tce_pkg::INDEX_W-1:0] idx, input logic has_fixed,
                                input console_result_t fixed_res);
        console_result_t res;
        while (!quiet && $urandom_range(0, 99) < IDLE_PERCENT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {{(tce_pkg::S_TDATA_W-tce_pkg::INDEX_W-tce_pkg::CHAR_W){1'b0}}, idx, ch};
        do @(posedge aclk); while (!s_tready);
        predict_console(req, ch, idx, res);
        pending_results.push_back(has_fixed ? fixed_res : res);
        // spare codes and off-screen writes leave the block untouched
        if (req <= tce_pkg::REQ_READ &&
            !(req == tce_pkg::REQ_WRITE_AT && idx >= tce_pkg::SCREEN_SIZE))
            stim_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    task automatic write_attribute(input logic [tce_pkg::ATTR_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        model_attr = value;
    endtask

    task automatic put_char(input logic [tce_pkg::CHAR_W-1:0] ch);
        send_request(tce_pkg::REQ_PUT, ch, tce_pkg::INDEX_W'($urandom_range(0, 2047)),
                     1'b0, '0);
    endtask

    function automatic logic [tce_pkg::CHAR_W-1:0] text_char();
        logic [tce_pkg::CHAR_W-1:0] ch;
        ch = tce_pkg::CHAR_W'($urandom_range(0, 255));
        if (ch == tce_pkg::NEWLINE_CODE)
            ch = ~ch;
        return ch;
    endfunction

    task automatic run_segment();
        int kind;
        int len;
        logic [tce_pkg::REQ_W-1:0]   req;
        logic [tce_pkg::INDEX_W-1:0] idx;
        kind = $urandom_range(0, 99);
        if (kind < 38) begin
            // ordinary line of text, usually ended by a newline
            len = $urandom_range(0, 40);
            repeat (len) put_char(text_char());
            if ($urandom_range(0, 4) != 0)
                put_char(tce_pkg::NEWLINE_CODE);
        end else if (kind < 50) begin
            // long run without newline: crosses rows and can wrap past the last cell
            len = $urandom_range(70, 130);
            repeat (len) put_char(text_char());
        end else if (kind < 60) begin
            len = $urandom_range(1, 6);
            repeat (len) put_char(tce_pkg::NEWLINE_CODE);
        end else if (kind < 75) begin
            len = $urandom_range(1, 12);
            repeat (len) begin
                req = tce_pkg::REQ_W'($urandom_range(0, 7));
                if (req == tce_pkg::REQ_CLEAR && $urandom_range(0, 3) != 0)
                    req = tce_pkg::REQ_READ;
                send_request(req, tce_pkg::CHAR_W'($urandom_range(0, 255)),
                             tce_pkg::INDEX_W'($urandom_range(0, 2047)), 1'b0, '0);
            end
        end else if (kind < 88) begin
            len = $urandom_range(1, 10);
            repeat (len) begin
                if ($urandom_range(0, 1) == 0) begin
                    last_written = $urandom_range(0, tce_pkg::SCREEN_SIZE - 1);
                    send_request(tce_pkg::REQ_WRITE_AT,
                                 tce_pkg::CHAR_W'($urandom_range(0, 255)),
                                 tce_pkg::INDEX_W'(last_written), 1'b0, '0);
                end else begin
                    idx = ($urandom_range(0, 1) == 0)
                        ? tce_pkg::INDEX_W'(last_written)
                        : tce_pkg::INDEX_W'($urandom_range(0, 2047));
                    send_request(tce_pkg::REQ_READ, tce_pkg::CHAR_W'($urandom_range(0, 255)),
                                 idx, 1'b0, '0);
                end
            end
        end else if (kind < 96) begin
            len = $urandom_range(1, 10);
            repeat (len)
                send_request(tce_pkg::REQ_BACKSPACE, tce_pkg::CHAR_W'($urandom_range(0, 255)),
                             tce_pkg::INDEX_W'($urandom_range(0, 2047)), 1'b0, '0);
        end else if (kind < 98) begin
            send_request(tce_pkg::REQ_CLEAR, tce_pkg::CHAR_W'($urandom_range(0, 255)),
                         tce_pkg::INDEX_W'($urandom_range(0, 2047)), 1'b0, '0);
        end else begin
            wait_drained();
        end
    endtask

    // result check against the oldest outstanding prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transfer, actual m_tdata %h", $time, m_tdata);
                fail_count++;
            end else begin
                oldest = pending_results.pop_front();
                if (m_tdata[tce_pkg::CURSOR_W-1:0] !== oldest.cursor) begin
                    $display("%0t: cursor_pos expected %0d actual %0d",
                             $time, oldest.cursor, m_tdata[tce_pkg::CURSOR_W-1:0]);
                    fail_count++;
                end
                if (m_tdata[tce_pkg::CURSOR_W +: tce_pkg::CELL_W] !== oldest.cell_data) begin
                    $display("%0t: cell_data expected %h actual %h",
                             $time, oldest.cell_data,
                             m_tdata[tce_pkg::CURSOR_W +: tce_pkg::CELL_W]);
                    fail_count++;
                end
                if (m_tdata[tce_pkg::M_TDATA_W-1:tce_pkg::CURSOR_W+tce_pkg::CELL_W] !== '0) begin
                    $display("%0t: m_tdata padding expected 0 actual %h", $time,
                             m_tdata[tce_pkg::M_TDATA_W-1:tce_pkg::CURSOR_W+tce_pkg::CELL_W]);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk)
        m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PERCENT);

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("text_console_engine_test: FAIL");
            $finish;
        end
    end

    initial begin
        int phase;
        int next_cfg;
        model_attr   = tce_pkg::RESET_ATTR;
        model_cursor = 0;
        for (int i = 0; i < tce_pkg::SCREEN_SIZE; i++)
            model_cells[i] = {tce_pkg::RESET_ATTR, tce_pkg::SPACE_CODE};

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed probes, reset attribute still in force
        for (int r = 0; r < NUM_PROBES; r++)
            send_request(PROBE_TABLE[r].req, PROBE_TABLE[r].ch, PROBE_TABLE[r].idx,
                         PROBE_TABLE[r].has_fixed, PROBE_TABLE[r].fixed_res);

        write_attribute(8'hFF);
        stim_count = 0;
        phase      = 1;
        next_cfg   = CFG_SPACING;
        while (stim_count < RANDOM_ITEMS) begin
            if (stim_count >= next_cfg) begin
                write_attribute(phase == 1 ? 8'h00 : tce_pkg::ATTR_W'($urandom_range(0, 255)));
                phase++;
                next_cfg += CFG_SPACING;
            end
            quiet = (stim_count >= 400 && stim_count < 560);
            run_segment();
        end
        quiet = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0)
            $display("text_console_engine_test: PASS");
        else
            $display("text_console_engine_test: FAIL");
        $finish;
    end

endmodule
